// ----- hdl/pretokenizer_piece_splitter_defines.svh -----
// ----------------------------------------------------------------------------
// Pretokenizer piece splitter: assertion macros
// Shared concurrent assertion forms, all disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PRETOKENIZER_PIECE_SPLITTER_DEFINES_SVH
`define PRETOKENIZER_PIECE_SPLITTER_DEFINES_SVH

// condition holds at every edge
`define PPS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define PPS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// Pretokenizer piece splitter package
// Beat types, run kinds, character constants and the character classes.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int unsigned CP_W = 21;

  typedef logic [CP_W-1:0] cp_t;

  typedef struct packed {
    cp_t  codepoint;
    logic last;
  } char_beat_t;

  typedef struct packed {
    cp_t  char_out;
    logic begins_piece;
    logic text_end;
  } piece_beat_t;

  typedef enum logic [4:0] {
    MODE_NONE   = 5'b00001,
    MODE_LETTER = 5'b00010,
    MODE_PUNCT  = 5'b00100,
    MODE_NLRUN  = 5'b01000,
    MODE_WS     = 5'b10000
  } mode_t;

  typedef struct packed {
    logic       emit;
    logic       begins;
    mode_t      mode_next;
    logic [1:0] skip_next;
  } head_dec_t;

  localparam cp_t CH_APOS  = 21'h27;
  localparam cp_t CH_SPACE = 21'h20;
  localparam cp_t LC_S     = 21'h73;
  localparam cp_t LC_T     = 21'h74;
  localparam cp_t LC_M     = 21'h6D;
  localparam cp_t LC_D     = 21'h64;
  localparam cp_t LC_R     = 21'h72;
  localparam cp_t LC_V     = 21'h76;
  localparam cp_t LC_L     = 21'h6C;
  localparam cp_t LC_E     = 21'h65;

  function automatic logic is_nl(cp_t c);
    return (c == 21'h0A) || (c == 21'h0D);
  endfunction

  function automatic logic is_ws(cp_t c);
    return (c == 21'h20) || (c == 21'h09) || (c == 21'h3000) || (c == 21'h00A0);
  endfunction

  function automatic logic is_digit(cp_t c);
    return c inside {[21'h30:21'h39]};
  endfunction

  function automatic logic is_letter(cp_t c);
    logic ascii_alpha;
    logic high_letter;
    ascii_alpha = c inside {[21'h41:21'h5A], [21'h61:21'h7A]};
    high_letter = (c > 21'h7F) && !is_ws(c) &&
                  !(c inside {[21'h2000:21'h206F], [21'h3000:21'h303F]});
    return ascii_alpha || high_letter;
  endfunction

  function automatic logic is_punct(cp_t c);
    logic res;
    if (c <= 21'h7F) begin
      res = c inside {[21'h21:21'h2F], [21'h3A:21'h40], [21'h5B:21'h60],
                      [21'h7B:21'h7E]};
    end else begin
      res = !is_letter(c) && !is_ws(c);
    end
    return res;
  endfunction

  function automatic cp_t lower_ascii(cp_t c);
    return (c inside {[21'h41:21'h5A]}) ? c + 21'h20 : c;
  endfunction

endpackage

// ----- hdl/pps_head_decide.sv -----
// ----------------------------------------------------------------------------
// Pretokenizer piece splitter: head decision
// Decides whether the oldest held codepoint can leave now, whether it opens a
// piece, and what run and contraction state it leaves behind.
// ----------------------------------------------------------------------------
module pps_head_decide
  import pps_pkg::*;
(
  input  cp_t        cp0,
  input  cp_t        cp1,
  input  cp_t        cp2,
  input  logic [2:0] held_last,
  input  logic [2:0] fill,
  input  mode_t      run_mode,
  input  logic [1:0] skip_count,
  output head_dec_t  dec
);

  logic  v0, v1, v2;
  logic  n_ok, m_ok, end_seen;
  cp_t   n, m;
  logic  cont;
  mode_t cont_mode;
  logic  wait_la, chosen;
  mode_t mode_new;
  logic [1:0] skip_new;

  always_comb begin
    v0 = fill != 3'd0;
    v1 = fill >= 3'd2;
    v2 = fill >= 3'd3;
    // lookahead never reaches past the end of the text
    n_ok     = v1 && !held_last[0];
    m_ok     = v2 && !held_last[0] && !held_last[1];
    end_seen = held_last[0] || (n_ok && held_last[1]) || (m_ok && held_last[2]);
    n = lower_ascii(cp1);
    m = lower_ascii(cp2);

    cont      = 1'b0;
    cont_mode = run_mode;
    case (run_mode)
      MODE_LETTER: cont = is_letter(cp0);
      MODE_PUNCT: begin
        if (is_punct(cp0)) begin
          cont = 1'b1;
        end else if (is_nl(cp0)) begin
          cont      = 1'b1;
          cont_mode = MODE_NLRUN;
        end
      end
      MODE_NLRUN: cont = is_nl(cp0);
      MODE_WS: begin
        if (is_ws(cp0)) begin
          cont = 1'b1;
        end else if (is_nl(cp0)) begin
          cont      = 1'b1;
          cont_mode = MODE_NLRUN;
        end
      end
      default: cont = 1'b0;
    endcase

    wait_la  = 1'b0;
    chosen   = 1'b0;
    mode_new = MODE_NONE;
    skip_new = 2'd0;
    if (cp0 == CH_APOS) begin
      if (!n_ok) begin
        wait_la = !end_seen;
      end else if (n == LC_S || n == LC_T || n == LC_M || n == LC_D) begin
        chosen   = 1'b1;
        skip_new = 2'd1;
      end else if (n == LC_R || n == LC_V || n == LC_L) begin
        if (!m_ok) begin
          wait_la = !end_seen;
        end else if (((n == LC_R || n == LC_V) && m == LC_E) ||
                     (n == LC_L && m == LC_L)) begin
          chosen   = 1'b1;
          skip_new = 2'd2;
        end
      end
    end
    if (!wait_la && !chosen) begin
      if (is_ws(cp0)) begin
        if (!n_ok && !end_seen) begin
          wait_la = 1'b1;
        end else if (n_ok && is_punct(cp1)) begin
          mode_new = MODE_PUNCT;
        end else if (cp0 == CH_SPACE && n_ok && is_letter(cp1)) begin
          mode_new = MODE_LETTER;
        end else begin
          mode_new = MODE_WS;
        end
      end else if (is_letter(cp0)) begin
        mode_new = MODE_LETTER;
      end else if (is_digit(cp0)) begin
        mode_new = MODE_NONE;
      end else if (is_nl(cp0)) begin
        mode_new = MODE_NLRUN;
      end else if (is_punct(cp0)) begin
        mode_new = MODE_PUNCT;
      end
    end

    dec.emit      = 1'b0;
    dec.begins    = 1'b0;
    dec.mode_next = run_mode;
    dec.skip_next = skip_count;
    if (!v0) begin
      dec.emit = 1'b0;
    end else if (skip_count != 2'd0) begin
      dec.emit      = 1'b1;
      dec.skip_next = skip_count - 2'd1;
    end else if (cont) begin
      dec.emit      = 1'b1;
      dec.mode_next = cont_mode;
    end else begin
      dec.emit      = !wait_la;
      dec.begins    = 1'b1;
      dec.mode_next = mode_new;
      dec.skip_next = skip_new;
    end
  end

endmodule

// ----- hdl/pretokenizer_piece_splitter.sv -----
// ----------------------------------------------------------------------------
// Pretokenizer piece splitter
// Marks the codepoints that start a pretoken piece, GPT-2 style.
// ----------------------------------------------------------------------------
// Usage:
//   char_*  : one codepoint per beat, last set on the final one of a text.
//   piece_* : every codepoint again, in order, one per beat, with
//             begins_piece and text_end.
//   Codepoints wait in a four-entry lookahead buffer until the piece that
//   starts at the oldest one can be chosen; that needs at most two later
//   codepoints of the same text, or its last beat.
//   A codepoint is held in the lookahead buffer and, once decidable, moves
//   into the output register; an apostrophe or whitespace may stay until up
//   to two more codepoints arrive. At the end of a text the held codepoints
//   drain one per cycle while piece_ready does not stall.
//   Throughput: one codepoint per cycle while piece_ready does not stall, set
//   by the single head decision per cycle into the output register.
//   char_ready is low only while the buffer holds four codepoints, which
//   happens only when piece_ready stalls; the output register holds its beat
//   until taken.
//   Reset empties the buffer and the output register and closes any run.
// ----------------------------------------------------------------------------
`include "pretokenizer_piece_splitter_defines.svh"

module pretokenizer_piece_splitter
  import pps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_ready,
  input  char_beat_t  char_item,
  output logic        piece_valid,
  input  logic        piece_ready,
  output piece_beat_t piece_item
);

  cp_t        lookahead_buffer [4];
  logic [3:0] held_last;
  logic [2:0] buffer_fill;
  mode_t      run_mode;
  logic [1:0] skip_count;

  cp_t        lookahead_buffer_next [4];
  logic [3:0] held_last_next;
  logic [2:0] buffer_fill_next;
  logic [2:0] wr_pos;
  head_dec_t  dec;
  logic       pop, push;

  pps_head_decide u_decide (
    .cp0        (lookahead_buffer[0]),
    .cp1        (lookahead_buffer[1]),
    .cp2        (lookahead_buffer[2]),
    .held_last  (held_last[2:0]),
    .fill       (buffer_fill),
    .run_mode   (run_mode),
    .skip_count (skip_count),
    .dec        (dec)
  );

  assign char_ready = buffer_fill != 3'd4;
  assign push       = char_valid && char_ready;
  assign pop        = dec.emit && (!piece_valid || piece_ready);
  assign wr_pos     = buffer_fill - {2'd0, pop};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lookahead_buffer_next[i] = lookahead_buffer[i];
      held_last_next[i]        = held_last[i];
    end
    if (pop) begin
      for (int i = 0; i < 3; i++) begin
        lookahead_buffer_next[i] = lookahead_buffer[i+1];
        held_last_next[i]        = held_last[i+1];
      end
    end
    if (push) begin
      lookahead_buffer_next[wr_pos[1:0]] = char_item.codepoint;
      held_last_next[wr_pos[1:0]]        = char_item.last;
    end
    buffer_fill_next = wr_pos + {2'd0, push};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      lookahead_buffer[i] <= lookahead_buffer_next[i];
    end
    held_last <= held_last_next;
    if (pop) begin
      piece_item.char_out     <= lookahead_buffer[0];
      piece_item.begins_piece <= dec.begins;
      piece_item.text_end     <= held_last[0];
    end
    if (rst) begin
      buffer_fill <= 3'd0;
      run_mode    <= MODE_NONE;
      skip_count  <= 2'd0;
      piece_valid <= 1'b0;
    end else begin
      buffer_fill <= buffer_fill_next;
      if (pop) begin
        // end of text closes every run
        run_mode   <= held_last[0] ? MODE_NONE : dec.mode_next;
        skip_count <= held_last[0] ? 2'd0 : dec.skip_next;
      end
      if (pop) begin
        piece_valid <= 1'b1;
      end else if (piece_ready) begin
        piece_valid <= 1'b0;
      end
    end
  end

  `PPS_ASSERT_ALWAYS(a_fill_range, clk, rst, buffer_fill <= 3'd4, "fill overflow")
  `PPS_ASSERT_IMPLIES(a_skip_held, clk, rst, skip_count != 2'd0, 3'(skip_count) <= buffer_fill, "tail not held")
  `PPS_ASSERT_IMPLIES(a_full_decides, clk, rst, buffer_fill == 3'd4, dec.emit, "full, head stuck")
  `PPS_ASSERT_NEXT(a_end_closes, clk, rst, pop && held_last[0], run_mode == MODE_NONE && skip_count == 2'd0, "run open")

endmodule

// ----- tb/pretokenizer_piece_splitter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pretokenizer piece splitter testbench
// Streams texts of codepoints through the splitter with random gaps on the
// input side and random stalls on the output side. A software copy of the
// splitting rules predicts every output beat. Each output beat is checked,
// in order, against the oldest predicted beat. Directed texts cover the
// contractions, the whitespace rules and the character classes. Random texts
// follow them.
// ----------------------------------------------------------------------------
module pretokenizer_piece_splitter_tb;
  import pps_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_ready;
  char_beat_t  char_item = '0;
  logic        piece_valid;
  logic        piece_ready = 1'b0;
  piece_beat_t piece_item;

  // splitter state as predicted
  cp_t   held [4];
  int    held_cnt;
  mode_t open_run;
  int    skip_left;

  piece_beat_t expected_pieces[$];
  piece_beat_t want_piece;
  cp_t         text_buf[$];
  int          mismatches = 0;
  int          chars_sent = 0;
  bit          no_gaps = 1'b0;

  pretokenizer_piece_splitter uut (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_item   (char_item),
    .piece_valid (piece_valid),
    .piece_ready (piece_ready),
    .piece_item  (piece_item)
  );

  always #4 clk = ~clk;

  function automatic bit nl_char(input cp_t c);
    return (c == 21'h0A) || (c == 21'h0D);
  endfunction

  function automatic bit ws_char(input cp_t c);
    return (c == 21'h20) || (c == 21'h09) || (c == 21'h3000) || (c == 21'h00A0);
  endfunction

  function automatic bit digit_char(input cp_t c);
    return (c >= 21'h30) && (c <= 21'h39);
  endfunction

  function automatic bit letter_char(input cp_t c);
    if ((c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A)) return 1'b1;
    if (c <= 21'h7F || ws_char(c)) return 1'b0;
    if (c >= 21'h2000 && c <= 21'h206F) return 1'b0;
    if (c >= 21'h3000 && c <= 21'h303F) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit punct_char(input cp_t c);
    if (c <= 21'h7F)
      return (c >= 21'h21 && c <= 21'h2F) || (c >= 21'h3A && c <= 21'h40) ||
             (c >= 21'h5B && c <= 21'h60) || (c >= 21'h7B && c <= 21'h7E);
    return !letter_char(c) && !ws_char(c);
  endfunction

  function automatic cp_t fold_case(input cp_t c);
    return (c >= 21'h41 && c <= 21'h5A) ? c + 21'h20 : c;
  endfunction

  // picks the piece that opens at the oldest held codepoint; 0 means wait
  function automatic bit choose_piece(input bit at_end);
    cp_t c;
    cp_t n;
    cp_t m;
    int  la;
    c = held[0];
    la = held_cnt - 1;
    open_run = MODE_NONE;
    if (c == CH_APOS) begin
      if (la < 1) begin
        if (!at_end) return 1'b0;
      end else begin
        n = fold_case(held[1]);
        if (n == LC_S || n == LC_T || n == LC_M || n == LC_D) begin
          skip_left = 1;
          return 1'b1;
        end
        if (n == LC_R || n == LC_V || n == LC_L) begin
          if (la < 2) begin
            if (!at_end) return 1'b0;
          end else begin
            m = fold_case(held[2]);
            if (((n == LC_R || n == LC_V) && m == LC_E) || (n == LC_L && m == LC_L)) begin
              skip_left = 2;
              return 1'b1;
            end
          end
        end
      end
    end
    if (ws_char(c)) begin
      if (la < 1 && !at_end) return 1'b0;
      if (la >= 1 && punct_char(held[1])) open_run = MODE_PUNCT;
      else if (c == CH_SPACE && la >= 1 && letter_char(held[1])) open_run = MODE_LETTER;
      else open_run = MODE_WS;
      return 1'b1;
    end
    if (letter_char(c)) open_run = MODE_LETTER;
    else if (digit_char(c)) open_run = MODE_NONE;
    else if (nl_char(c)) open_run = MODE_NLRUN;
    else if (punct_char(c)) open_run = MODE_PUNCT;
    return 1'b1;
  endfunction

  function automatic bit extends_run(input cp_t c);
    case (open_run)
      MODE_LETTER: return letter_char(c);
      MODE_PUNCT: begin
        if (punct_char(c)) return 1'b1;
        if (nl_char(c)) begin
          open_run = MODE_NLRUN;
          return 1'b1;
        end
        return 1'b0;
      end
      MODE_NLRUN: return nl_char(c);
      MODE_WS: begin
        if (ws_char(c)) return 1'b1;
        if (nl_char(c)) begin
          open_run = MODE_NLRUN;
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic clear_split_state();
    int i;
    for (i = 0; i < 4; i++) held[i] = '0;
    held_cnt = 0;
    open_run = MODE_NONE;
    skip_left = 0;
  endtask

  task automatic predict_pieces(input cp_t cp, input bit at_end);
    int          emitted;
    int          i;
    bit          go;
    bit          begins;
    cp_t         c;
    piece_beat_t p;
    emitted = 0;
    go = 1'b1;
    if (held_cnt < 4) begin
      held[held_cnt] = cp;
      held_cnt++;
    end
    while (go && held_cnt > 0 && emitted < 4) begin
      c = held[0];
      begins = 1'b0;
      if (skip_left > 0) begin
        skip_left--;
      end else if (!extends_run(c)) begin
        if (choose_piece(at_end)) begin
          begins = 1'b1;
        end else begin
          go = 1'b0;
        end
      end
      if (go) begin
        p.char_out = c;
        p.begins_piece = begins;
        p.text_end = at_end && (held_cnt == 1);
        expected_pieces.insert(expected_pieces.size(), p);
        emitted++;
        for (i = 0; i < 3; i++) held[i] = held[i + 1];
        held_cnt--;
        held[held_cnt] = '0;
      end
    end
    if (at_end) clear_split_state();
  endtask

  task automatic send_char(input cp_t cp, input bit fin);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_valid <= 1'b1;
    char_item.codepoint <= cp;
    char_item.last <= fin;
    predict_pieces(cp, fin);
    chars_sent++;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_buf.size(); i++)
      send_char(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  function automatic cp_t random_char();
    cp_t c;
    case ($urandom_range(0, 15))
      0, 1, 2, 14, 15: c = cp_t'($urandom_range(0, 25)) +
                           ($urandom_range(0, 1) ? 21'h41 : 21'h61);
      3:  c = cp_t'($urandom_range(21'h30, 21'h39));
      4:  c = CH_SPACE;
      5: begin
        case ($urandom_range(0, 2))
          0:       c = 21'h09;
          1:       c = 21'h3000;
          default: c = 21'h00A0;
        endcase
      end
      6:  c = $urandom_range(0, 1) ? 21'h0A : 21'h0D;
      7, 8: begin
        do c = cp_t'($urandom_range(21'h21, 21'h7E)); while (!punct_char(c));
      end
      9:  c = CH_APOS;
      10: c = cp_t'($urandom_range(21'h80, 21'h1FFFFF));
      11: c = $urandom_range(0, 1) ? cp_t'($urandom_range(21'h2000, 21'h206F))
                                   : cp_t'($urandom_range(21'h3000, 21'h303F));
      12: c = ($urandom_range(0, 3) == 0) ? 21'h7F : cp_t'($urandom_range(0, 21'h1F));
      default: c = cp_t'($urandom_range(0, 21'h1FFFFF));
    endcase
    return c;
  endfunction

  function automatic cp_t random_case(input cp_t c);
    return $urandom_range(0, 1) ? c - 21'h20 : c;
  endfunction

  task automatic test_contractions();
    text_buf = '{CH_APOS, 21'h53, CH_APOS, LC_R, 21'h45, CH_APOS, LC_L, 21'h78};
    send_text();
    text_buf = '{CH_APOS};
    send_text();
    text_buf = '{CH_APOS, 21'h56};
    send_text();
  endtask

  task automatic test_spacing();
    text_buf = '{CH_SPACE, 21'h21, 21'h0A, CH_SPACE, 21'h61, 21'h09, 21'h3000, 21'h0D,
                 21'h00A0};
    send_text();
  endtask

  task automatic test_char_classes();
    text_buf = '{21'h30, 21'h39, 21'h1FFFFF, 21'h2000, 21'h000000};
    send_text();
  endtask

  task automatic test_random_text();
    int len;
    int k;
    int suffix;
    cp_t tails [7];
    tails = '{LC_S, LC_T, LC_M, LC_D, LC_R, LC_V, LC_L};
    while (chars_sent < 310) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      len = $urandom_range(1, 14);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          // apostrophe with a whole or broken contraction tail
          suffix = $urandom_range(0, 6);
          text_buf.insert(text_buf.size(), CH_APOS);
          text_buf.insert(text_buf.size(), random_case(tails[suffix]));
          if (suffix >= 4 && $urandom_range(0, 2) != 0)
            text_buf.insert(text_buf.size(), random_case(suffix == 6 ? LC_L : LC_E));
        end else begin
          text_buf.insert(text_buf.size(), random_char());
        end
      end
      send_text();
    end
  endtask

  initial begin : piece_sink
    int stall;
    @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        piece_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      piece_ready <= 1'b1;
      @(posedge clk);
      while (!piece_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && piece_valid && piece_ready) begin
      if (expected_pieces.size() == 0) begin
        $display("%0t: unexpected beat char %h begins %b end %b", $time,
                 piece_item.char_out, piece_item.begins_piece, piece_item.text_end);
        mismatches++;
      end else begin
        want_piece = expected_pieces.pop_front();
        if (piece_item.char_out !== want_piece.char_out ||
            piece_item.begins_piece !== want_piece.begins_piece ||
            piece_item.text_end !== want_piece.text_end) begin
          $display("%0t: expected char %h begins %b end %b, got char %h begins %b end %b",
                   $time, want_piece.char_out, want_piece.begins_piece,
                   want_piece.text_end, piece_item.char_out, piece_item.begins_piece,
                   piece_item.text_end);
          mismatches++;
        end
      end
    end
  end

  initial begin
    clear_split_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_contractions();
    test_spacing();
    test_char_classes();
    test_random_text();
    @(negedge clk);
    char_valid <= 1'b0;
    while (expected_pieces.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/pps_pkg.sv
hdl/pps_head_decide.sv
hdl/pretokenizer_piece_splitter.sv
tb/pretokenizer_piece_splitter_tb.sv
